### rtl/round_robin_queue_with_expedite_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the round-robin queue with expedite
// Same-cycle and next-cycle implication checks, clocked on clk_i and
// disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_QUEUE_WITH_EXPEDITE_ASSERT_SVH
`define ROUND_ROBIN_QUEUE_WITH_EXPEDITE_ASSERT_SVH

// check that cons holds in the cycle where ante holds
`define RRQE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// check that cons holds in the cycle after ante holds
`define RRQE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/rrqe_pkg.sv
// ----------------------------------------------------------------------------
// rrqe_pkg
// Shared constants, codes and types of the round-robin queue with expedite.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rrqe_pkg;

  // field widths on the ports
  localparam int unsigned IdFieldW = 32;
  localparam int unsigned CfgW     = 7;

  // defaults of the top-level parameters
  localparam int unsigned DefCapacity = 64;
  localparam int unsigned DefIdWidth  = 32;

  // item mode codes
  localparam logic MODE_SERVE    = 1'b0;
  localparam logic MODE_EXPEDITE = 1'b1;

  // result status codes
  localparam logic STATUS_SERVED   = 1'b0;
  localparam logic STATUS_REJECTED = 1'b1;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_APPLY
  } state_e;

  // command broadcast to every cell of the chain
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_LOAD,
    OP_SERVE,
    OP_MATCH,
    OP_APPLY
  } cell_op_e;

endpackage

`default_nettype wire

### rtl/rrqe_if.sv
// ----------------------------------------------------------------------------
// rrqe_in_if / rrqe_out_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rrqe_in_if;
  import rrqe_pkg::*;

  logic                valid;
  logic                ready;
  logic                mode;
  logic [IdFieldW-1:0] id;

  modport source (output valid, output mode, output id, input ready);
  modport sink   (input valid, input mode, input id, output ready);
endinterface

interface rrqe_out_if;
  import rrqe_pkg::*;

  logic                valid;
  logic                ready;
  logic [IdFieldW-1:0] served_id;
  logic                status;

  modport source (output valid, output served_id, output status, input ready);
  modport sink   (input valid, input served_id, input status, output ready);
endinterface

`default_nettype wire

### rtl/round_robin_queue_with_expedite.sv
// ----------------------------------------------------------------------------
// round_robin_queue_with_expedite
// Ordered list of distinct IDs in a chain of cells: serve rotates the front
// ID to the back, expedite moves or inserts an ID at the front (rejected when full).
// ----------------------------------------------------------------------------
// Results: a served ID is loaded into the result register in the exec state,
//   a rejection in the apply state; both wait while a result is still held.
// Sequencer: accept in idle, then rotate the chain for a serve, or compare
//   across all cells and then shift the chain for an expedite; a new item is
//   accepted only when the sequencer is back in idle.
// Reset: the list holds ID 1 only; a write on cfg_we_i reloads IDs 1..n,
//   n being cfg_data_i clamped to the capacity and to the ID range.
`timescale 1ns / 1ps
`default_nettype none

`include "round_robin_queue_with_expedite_assert.svh"

module round_robin_queue_with_expedite #(
  parameter int unsigned CAPACITY = rrqe_pkg::DefCapacity,
  parameter int unsigned ID_WIDTH = rrqe_pkg::DefIdWidth
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [rrqe_pkg::CfgW-1:0] cfg_data_i,
  rrqe_in_if.sink                        in_i,
  rrqe_out_if.source                     out_o
);
  import rrqe_pkg::*;

  localparam int unsigned       CntW  = $clog2(CAPACITY + 1);
  localparam longint unsigned   IdMax = (64'd1 << ID_WIDTH) - 64'd1;
  localparam int unsigned       Limit = (longint'(CAPACITY) < IdMax) ? CAPACITY
                                                                     : int'(IdMax);

  state_e              state_q, state_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                mode_q;
  logic [ID_WIDTH-1:0] id_q;
  logic                out_valid_q;
  logic [ID_WIDTH-1:0] out_id_q;
  logic                out_status_q;

  cell_op_e            cell_op;
  logic                out_load;
  logic                out_reject;
  logic                count_inc;
  logic                out_free;
  logic                full;
  logic                hit;
  logic [CntW-1:0]     hit_pos;
  logic [CntW-1:0]     apply_pos;
  logic [CntW-1:0]     load_count;

  logic [ID_WIDTH-1:0] vals    [CAPACITY];
  logic [ID_WIDTH-1:0] left_w  [CAPACITY];
  logic [ID_WIDTH-1:0] right_w [CAPACITY];
  logic [CAPACITY-1:0] match_vec;

  // build the chain of list cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_w[i] = '0;
    end else begin : g_left
      assign left_w[i] = vals[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w[i] = '0;
    end else begin : g_right
      assign right_w[i] = vals[i+1];
    end

    rrqe_cell #(
      .IDX      (i),
      .ID_WIDTH (ID_WIDTH),
      .CNT_W    (CntW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .op_i    (cell_op),
      .count_i (count_q),
      .pos_i   (apply_pos),
      .id_i    (id_q),
      .left_i  (left_w[i]),
      .right_i (right_w[i]),
      .front_i (vals[0]),
      .value_o (vals[i]),
      .match_o (match_vec[i])
    );
  end

  // encode the single matching slot into its position
  always_comb begin
    hit_pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (match_vec[i]) begin
        hit_pos = hit_pos | CntW'(i);
      end
    end
  end

  assign hit       = |match_vec;
  assign apply_pos = hit ? hit_pos : count_q;
  assign full      = (count_q == CntW'(CAPACITY));
  assign out_free  = !out_valid_q || out_o.ready;

  // clamp the configured count to capacity and to distinct IDs
  assign load_count = (32'(cfg_data_i) > 32'(Limit)) ? CntW'(Limit) : CntW'(cfg_data_i);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (mode_q == MODE_EXPEDITE) begin
          state_d = ST_APPLY;
        end else if (count_q == '0 || out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_APPLY: begin
        if (hit || !full || out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    cell_op    = OP_HOLD;
    out_load   = 1'b0;
    out_reject = 1'b0;
    count_inc  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        cell_op = OP_HOLD;
      end
      ST_EXEC: begin
        if (mode_q == MODE_EXPEDITE) begin
          cell_op = OP_MATCH;
        end else if (count_q != '0 && out_free) begin
          cell_op  = OP_SERVE;
          out_load = 1'b1;
        end
      end
      ST_APPLY: begin
        if (hit || !full) begin
          cell_op   = OP_APPLY;
          count_inc = !hit;
        end else if (out_free) begin
          out_load   = 1'b1;
          out_reject = 1'b1;
        end
      end
      default: begin
        cell_op = OP_HOLD;
      end
    endcase
    // reload the chain on a register write
    if (cfg_we_i) begin
      cell_op = OP_LOAD;
    end
  end

  assign in_i.ready = (state_q == ST_IDLE);

  // advance the entry count
  always_comb begin
    count_d = count_q;
    if (cfg_we_i) begin
      count_d = load_count;
    end else if (count_inc) begin
      count_d = count_q + CntW'(1);
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= CntW'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // capture the accepted item and the result payload
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      mode_q <= in_i.mode;
      id_q   <= in_i.id[ID_WIDTH-1:0];
    end
    if (out_load) begin
      out_id_q     <= out_reject ? '0 : vals[0];
      out_status_q <= out_reject ? STATUS_REJECTED : STATUS_SERVED;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.served_id = IdFieldW'(out_id_q);
  assign out_o.status    = out_status_q;

  `RRQE_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CntW'(CAPACITY), "entry count above capacity")
  `RRQE_ASSERT_NOW(a_match_unique, state_q == ST_APPLY, $onehot0(match_vec), "ID listed twice")
  `RRQE_ASSERT_NEXT(a_accept_exec, in_i.valid && in_i.ready && !cfg_we_i, state_q == ST_EXEC, "accepted item not executed")
  `RRQE_ASSERT_NEXT(a_reject_full, state_q == ST_APPLY && !hit && full && out_free, out_valid_q && out_status_q == STATUS_REJECTED, "full-list expedite not rejected")
  `RRQE_ASSERT_NEXT(a_empty_serve, state_q == ST_EXEC && mode_q == MODE_SERVE && count_q == '0, state_q == ST_IDLE, "empty serve did not finish")

endmodule

`default_nettype wire

### rtl/rrqe_cell.sv
// ----------------------------------------------------------------------------
// rrqe_cell
// One list slot: holds an ID, compares it against a broadcast ID and takes
// its left or right neighbor's ID when the list rotates or shifts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rrqe_cell #(
  parameter int unsigned IDX      = 0,
  parameter int unsigned ID_WIDTH = 32,
  parameter int unsigned CNT_W    = 7
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire rrqe_pkg::cell_op_e   op_i,
  input  wire logic [CNT_W-1:0]     count_i,
  input  wire logic [CNT_W-1:0]     pos_i,
  input  wire logic [ID_WIDTH-1:0]  id_i,
  input  wire logic [ID_WIDTH-1:0]  left_i,
  input  wire logic [ID_WIDTH-1:0]  right_i,
  input  wire logic [ID_WIDTH-1:0]  front_i,
  output logic      [ID_WIDTH-1:0]  value_o,
  output logic                      match_o
);
  import rrqe_pkg::*;

  localparam logic [CNT_W-1:0]    MyIdx   = CNT_W'(IDX);
  localparam logic [CNT_W-1:0]    MyNext  = CNT_W'(IDX + 1);
  localparam logic [ID_WIDTH-1:0] LoadId  = ID_WIDTH'(IDX + 1);

  logic [ID_WIDTH-1:0] value_q, value_d;
  logic                match_q, match_d;

  // select the next slot content from the broadcast command
  always_comb begin
    value_d = value_q;
    match_d = match_q;
    case (op_i)
      OP_LOAD: begin
        value_d = LoadId;
      end
      OP_SERVE: begin
        // rotate: take right neighbor, last valid slot takes the front ID
        if (MyNext < count_i) begin
          value_d = right_i;
        end else if (MyNext == count_i) begin
          value_d = front_i;
        end
      end
      OP_MATCH: begin
        match_d = (value_q == id_i) && (MyIdx < count_i);
      end
      OP_APPLY: begin
        // front slot takes the expedited ID, slots up to pos shift back
        if (IDX == 0) begin
          value_d = id_i;
        end else if (MyIdx <= pos_i) begin
          value_d = left_i;
        end
      end
      default: begin
        value_d = value_q;
      end
    endcase
  end

  // hold slot content and compare flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q <= LoadId;
      match_q <= 1'b0;
    end else begin
      value_q <= value_d;
      match_q <= match_d;
    end
  end

  assign value_o = value_q;
  assign match_o = match_q;

endmodule

`default_nettype wire
